### rtl/msc_pkg.sv
// shared types and constants for the mesi snooping coherence block
// no dependencies
`default_nettype none
package msc_pkg;
  localparam int CORES      = 4;
  localparam int SET_BITS   = 12;
  localparam int WAYS       = 2;
  localparam int BLOCK_BITS = 5;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = ADDR_W - SET_BITS - BLOCK_BITS;
  localparam int NSETS      = 1 << SET_BITS;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W     = WAY_W;
  localparam int LAT_W      = 10;
  localparam int STALL_W    = 11;
  localparam logic [LAT_W-1:0] MEM_LATENCY_RESET = LAT_W'(100);

  // line state codes
  localparam logic [1:0] ST_M = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_S = 2'd2;
  localparam logic [1:0] ST_I = 2'd3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [1:0]        st;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] core_row_t;
  typedef core_row_t [CORES-1:0] set_row_t;
endpackage
`default_nettype wire

### rtl/mesi_snooping_cache_coherence.sv
// mesi snooping coherence engine: per-set row memory of all caches, read-modify-write
// depends on msc_pkg
// row read is registered at the input transfer, the result at the write back
// the write back waits on a stalled result; input stalled until it is done
// reset: a pass over all 4096 sets marks every line invalid; input stalled meanwhile
// reset loads mem_latency with 100; configuration writes are taken at any time
`default_nettype none
module mesi_snooping_cache_coherence (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [msc_pkg::LAT_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_core,
  input  wire logic                        in_op,
  input  wire logic [msc_pkg::ADDR_W-1:0]  in_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [1:0]                       out_new_state,
  output logic                             out_way_used,
  output logic                             out_evicted,
  output logic                             out_victim_writeback,
  output logic [3:0]                       out_snoop_writeback_mask,
  output logic [3:0]                       out_invalidate_mask,
  output logic [msc_pkg::STALL_W-1:0]      out_stall_cycles
);
  import msc_pkg::*;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SET_BITS-1:0] clr_r;
  logic [LAT_W-1:0]    lat_r;
  set_row_t            mem [NSETS];
  set_row_t            rd_r;
  logic [SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]    tag_r;
  logic [1:0]          core_r;
  logic                op_r;
  logic                in_xfer, do_wr;
  set_row_t            wr_row, clr_row;

  // result of the current item
  logic                hit_c, evict_c, vwb_c;
  logic [1:0]          nst_c;
  logic [WAY_W-1:0]    way_c;
  logic [3:0]          wbm_c, invm_c;
  logic [STALL_W-1:0]  stall_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign do_wr     = (state_r == S_RMW) && (!out_valid || !out_stall);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= MEM_LATENCY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lat_r <= cfg_data;
    end
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == {SET_BITS{1'b1}}) state_nxt = S_IDLE;
      S_IDLE: if (in_xfer) state_nxt = S_RMW;
      S_RMW:  if (do_wr) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
    end
  end

  // capture the access
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      set_r  <= in_address[BLOCK_BITS +: SET_BITS];
      tag_r  <= in_address[ADDR_W-1 -: TAG_W];
      core_r <= in_core;
      op_r   <= in_op;
    end
  end

  // row memory: registered read on transfer, write back or clear
  always_comb begin
    for (int c = 0; c < CORES; c++) begin
      for (int w = 0; w < WAYS; w++) begin
        clr_row[c][w] = '{tag: '0, st: ST_I, rank: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      mem[clr_r] <= clr_row;
    end else if (do_wr) begin
      mem[set_r] <= wr_row;
    end
    if (in_xfer) begin
      rd_r <= mem[in_address[BLOCK_BITS +: SET_BITS]];
    end
  end

  // coherence update of one set
  always_comb begin
    logic [CORES-1:0] hv;
    logic [WAY_W-1:0] hw [CORES];
    logic             shared, found;
    logic [WAY_W-1:0] vw;
    logic [RANK_W-1:0] best, old;
    set_row_t         r;
    r       = rd_r;
    hit_c   = 1'b0;
    evict_c = 1'b0;
    vwb_c   = 1'b0;
    nst_c   = ST_M;
    way_c   = '0;
    wbm_c   = '0;
    invm_c  = '0;
    stall_c = '0;
    shared  = 1'b0;
    found   = 1'b0;
    vw      = '0;
    best    = '0;
    old     = '0;
    // tag lookup in every cache, lowest way wins
    for (int c = 0; c < CORES; c++) begin
      hv[c] = 1'b0;
      hw[c] = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (rd_r[c][w].st != ST_I && rd_r[c][w].tag == tag_r) begin
          hv[c] = 1'b1;
          hw[c] = WAY_W'(w);
        end
      end
    end
    if ({1'b0, core_r} < 3'(CORES)) begin
      if (hv[core_r]) begin
        hit_c = 1'b1;
        vw    = hw[core_r];
        if (op_r == OP_WRITE) begin
          if (rd_r[core_r][vw].st == ST_S) begin
            for (int c = 0; c < CORES; c++) begin
              if (c != int'(core_r) && hv[c]) begin
                r[c][hw[c]].st = ST_I;
                invm_c[c] = 1'b1;
              end
            end
          end
          r[core_r][vw].st = ST_M;
        end
      end else begin
        // snoop the other caches
        for (int c = 0; c < CORES; c++) begin
          if (c != int'(core_r) && hv[c]) begin
            if (op_r == OP_READ) begin
              if (rd_r[c][hw[c]].st == ST_M) wbm_c[c] = 1'b1;
              r[c][hw[c]].st = ST_S;
              shared = 1'b1;
            end else begin
              r[c][hw[c]].st = ST_I;
              invm_c[c] = 1'b1;
            end
          end
        end
        // victim: first empty way, else oldest rank, lowest way on ties
        best = rd_r[core_r][0].rank;
        for (int w = 0; w < WAYS; w++) begin
          if (!found) begin
            if (rd_r[core_r][w].st == ST_I) begin
              found = 1'b1;
              vw    = WAY_W'(w);
            end else if (w == 0 || rd_r[core_r][w].rank > best) begin
              best = rd_r[core_r][w].rank;
              vw   = WAY_W'(w);
            end
          end
        end
        if (rd_r[core_r][vw].st != ST_I) begin
          evict_c = 1'b1;
          vwb_c   = (rd_r[core_r][vw].st == ST_M);
        end
        r[core_r][vw].tag = tag_r;
        r[core_r][vw].st  = (op_r == OP_WRITE) ? ST_M : (shared ? ST_S : ST_E);
        stall_c = vwb_c ? {lat_r, 1'b0} : {1'b0, lat_r};
      end
      // lru touch of the used way
      old = rd_r[core_r][vw].rank;
      for (int w = 0; w < WAYS; w++) begin
        if (WAY_W'(w) != vw && rd_r[core_r][w].rank <= old
            && rd_r[core_r][w].rank < RANK_W'(WAYS - 1)) begin
          r[core_r][w].rank = rd_r[core_r][w].rank + 1'b1;
        end
      end
      r[core_r][vw].rank = '0;
      nst_c = r[core_r][vw].st;
      way_c = vw;
    end
    wr_row = r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (do_wr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      out_hit                  <= hit_c;
      out_new_state            <= nst_c;
      out_way_used             <= way_c[0];
      out_evicted              <= evict_c;
      out_victim_writeback     <= vwb_c;
      out_snoop_writeback_mask <= wbm_c;
      out_invalidate_mask      <= invm_c;
      out_stall_cycles         <= stall_c;
    end
  end
endmodule
`default_nettype wire

### rtl/msc_checker.sv
// port-level checks for the mesi snooping coherence block, bound to the top level
// depends on msc_pkg
`default_nettype none
module msc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_hit,
  input wire logic                        out_evicted,
  input wire logic                        out_victim_writeback,
  input wire logic [3:0]                  out_snoop_writeback_mask,
  input wire logic [msc_pkg::STALL_W-1:0] out_stall_cycles
);
  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_stall_cycles) && $stable(out_hit))
    else $error("stalled result changed");

  // a hit has no fill, no eviction and no snoop flush
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_stall_cycles == '0 && !out_evicted
      && out_snoop_writeback_mask == 4'd0)
    else $error("hit with miss side effects");

  // victim writeback only with an eviction
  a_vwb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_victim_writeback |-> out_evicted && !out_hit)
    else $error("writeback without eviction");
endmodule

bind mesi_snooping_cache_coherence msc_checker u_msc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_hit(out_hit), .out_evicted(out_evicted),
  .out_victim_writeback(out_victim_writeback),
  .out_snoop_writeback_mask(out_snoop_writeback_mask),
  .out_stall_cycles(out_stall_cycles)
);
`default_nettype wire
